>>> hdl/aigcnf_pkg.sv
// Shared widths, codes and state types of the AIG to CNF encoder.
`default_nettype none

package aigcnf_pkg;

   // Request and response field widths
   localparam int REQ_TYPE_W = 2;
   localparam int LIT_W      = 17;
   localparam int NAME_W     = 20;
   localparam int CLIT_W     = 21;
   localparam int CNT_W      = 2;
   localparam int VTOT_W     = 20;
   localparam int CTOT_W     = 24;

   // Default sizing of the renaming table and CNF variable space
   localparam int GRAPH_VARS_DEF   = 65536;
   localparam int CNF_VAR_BITS_DEF = 20;

   // Request kinds
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_DECLARE = 2'd0,
      REQ_RESERVE = 2'd1,
      REQ_GATE    = 2'd2,
      REQ_BIND    = 2'd3
   } req_kind_type;

   // Clause patterns an item reduces to
   typedef enum logic [1:0] {
      FORM_NEG1  = 2'd0,
      FORM_POS1  = 2'd1,
      FORM_TWO   = 2'd2,
      FORM_THREE = 2'd3
   } form_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR   = 3'd0,
      ST_IDLE    = 3'd1,
      ST_INDEX   = 3'd2,
      ST_DECLARE = 3'd3,
      ST_LOOKUP  = 3'd4,
      ST_EMIT    = 3'd5
   } state_type;

endpackage

`default_nettype wire

>>> hdl/aigcnf_req_if.sv
// Request channel: one AIG item per handshake.
`default_nettype none

interface aigcnf_req_if import aigcnf_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [LIT_W-1:0]      lit_a;
   logic [LIT_W-1:0]      lit_b;
   logic [LIT_W-1:0]      lit_c;
   logic [NAME_W-1:0]     var_name;

   modport source (
      output valid, req_type, lit_a, lit_b, lit_c, var_name,
      input  ready
   );

   modport sink (
      input  valid, req_type, lit_a, lit_b, lit_c, var_name,
      output ready
   );

endinterface

`default_nettype wire

>>> hdl/aigcnf_rsp_if.sv
// Response channel: one CNF clause per handshake.
`default_nettype none

interface aigcnf_rsp_if import aigcnf_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [CLIT_W-1:0] clause_lit0;
   logic signed [CLIT_W-1:0] clause_lit1;
   logic signed [CLIT_W-1:0] clause_lit2;
   logic [CNT_W-1:0]         lit_count;
   logic                     last_clause;
   logic [VTOT_W-1:0]        var_total;
   logic [CTOT_W-1:0]        clause_total;
   logic                     overflow;

   modport source (
      output valid, clause_lit0, clause_lit1, clause_lit2, lit_count,
             last_clause, var_total, clause_total, overflow,
      input  ready
   );

   modport sink (
      input  valid, clause_lit0, clause_lit1, clause_lit2, lit_count,
             last_clause, var_total, clause_total, overflow,
      output ready
   );

endinterface

`default_nettype wire

>>> hdl/aigcnf_idx_mod.sv
// Two-stage reduction of a graph variable to a renaming table index.
`default_nettype none

module aigcnf_idx_mod import aigcnf_pkg::*; #(
   parameter int GRAPH_VARS = GRAPH_VARS_DEF
) (
   input  wire logic                            clock,
   input  wire logic [LIT_W-2:0]                graph_var,
   output logic      [$clog2(GRAPH_VARS)-1:0]   table_idx
);

   localparam int IDX_W   = $clog2(GRAPH_VARS);
   localparam int GV_W    = LIT_W - 1;
   localparam bit IS_POW2 = ((GRAPH_VARS & (GRAPH_VARS - 1)) == 0);
   localparam bit NO_MOD  = IS_POW2 || (GRAPH_VARS >= (1 << GV_W));

   generate
      if (NO_MOD) begin : g_mask
         logic [GV_W-1:0] v1_ff;
         logic [GV_W-1:0] v2_ff;

         // Match the latency of the reciprocal path
         always_ff @(posedge clock) begin
            v1_ff <= graph_var;
            v2_ff <= v1_ff;
         end

         // Power of two or no wrap: keep the low bits
         assign table_idx = IDX_W'(v2_ff);
      end else begin : g_recip
         localparam logic [31:0]     RECIP = 32'((64'd1 << 32) / GRAPH_VARS);
         localparam logic [GV_W-1:0] MOD_V = GV_W'(GRAPH_VARS);

         logic [GV_W-1:0] v1_ff;
         logic [47:0]     prod_ff;
         logic [GV_W-1:0] quot;
         logic [GV_W-1:0] qmul;
         logic [GV_W-1:0] rem_ff;

         // Estimate the quotient, low by at most one
         always_ff @(posedge clock) begin
            v1_ff   <= graph_var;
            prod_ff <= 48'(graph_var) * 48'(RECIP);
         end

         assign quot = prod_ff[47:32];
         assign qmul = GV_W'(32'(quot) * 32'(MOD_V));

         always_ff @(posedge clock) begin
            rem_ff <= v1_ff - qmul;
         end

         // Correct the remainder with one compare and subtract
         assign table_idx = (rem_ff >= MOD_V) ? IDX_W'(rem_ff - MOD_V) : IDX_W'(rem_ff);
      end
   endgenerate

endmodule

`default_nettype wire

>>> hdl/aig_to_cnf_tseitin_encoder_core.sv
// Top level: Tseitin encoding of AIG items into CNF clauses around one renaming memory.
// Steps: a reserve ends when taken; a declare waits out the index reduction, then writes the
// name; a gate or bind waits, makes L lookups (1 to 3, none for a bind to a constant), then
// hands out C clauses (1 to 3). Throughput: one item at a time, set by the one-read,
// one-write renaming memory and the registered index reduction ahead of it.
// Reset: control clears at once, then a pass over every entry clears the table.
`default_nettype none

module aig_to_cnf_tseitin_encoder_core import aigcnf_pkg::*; #(
   parameter int GRAPH_VARS   = GRAPH_VARS_DEF,
   parameter int CNF_VAR_BITS = CNF_VAR_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   aigcnf_req_if.sink    req_ch,
   aigcnf_rsp_if.source  rsp_ch
);

   localparam int               IDX_W   = $clog2(GRAPH_VARS);
   localparam int               VW      = CNF_VAR_BITS;
   localparam int               WORD_W  = VW + 1;
   localparam logic [VW-1:0]    VAR_MAX = {VW{1'b1}};
   localparam logic [31:0]      VAR_MAX32 = 32'(VAR_MAX);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(GRAPH_VARS - 1);

   // Sequencer and item registers
   state_type          state_ff,   state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic               wait_ff,    wait_in;
   logic [1:0]         step_ff,    step_in;
   logic [1:0]         emit_ff,    emit_in;
   req_kind_type       kind_ff,    kind_in;
   form_type           form_ff,    form_in;
   logic [1:0]         nlook_ff,   nlook_in;
   logic               bind_ff,    bind_in;
   logic [VW-1:0]      name_ff,    name_in;
   logic [LIT_W-1:0]   slot0_ff,   slot0_in;
   logic [LIT_W-1:0]   slot1_ff,   slot1_in;
   logic [LIT_W-1:0]   slot2_ff,   slot2_in;
   logic [CLIT_W-1:0]  lit_l_ff,   lit_l_in;
   logic [CLIT_W-1:0]  lit_r0_ff,  lit_r0_in;
   logic [CLIT_W-1:0]  lit_r1_ff,  lit_r1_in;

   // Counters and flags
   logic [VW-1:0]      fresh_ff,   fresh_in;
   logic               ovf_ff,     ovf_in;
   logic [CTOT_W-1:0]  ccount_ff,  ccount_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CLIT_W-1:0]  out_lit0_ff,  out_lit0_in;
   logic [CLIT_W-1:0]  out_lit1_ff,  out_lit1_in;
   logic [CLIT_W-1:0]  out_lit2_ff,  out_lit2_in;
   logic [CNT_W-1:0]   out_cnt_ff,   out_cnt_in;
   logic               out_last_ff,  out_last_in;
   logic [VTOT_W-1:0]  out_vtot_ff,  out_vtot_in;
   logic [CTOT_W-1:0]  out_ctot_ff,  out_ctot_in;
   logic               out_ovf_ff,   out_ovf_in;

   // Renaming memory: {valid, cnf variable}
   logic [WORD_W-1:0]  mem [GRAPH_VARS];
   logic [WORD_W-1:0]  rd_data_ff;
   logic               fwd_hit_ff;
   logic [WORD_W-1:0]  fwd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [WORD_W-1:0]  mem_wd;
   logic [IDX_W-1:0]   mem_ra;

   // Table indexes of the three lookup slots
   logic [IDX_W-1:0]   idx0;
   logic [IDX_W-1:0]   idx1;
   logic [IDX_W-1:0]   idx2;

   // Lookup datapath
   logic [WORD_W-1:0]  look_word;
   logic               look_alloc;
   logic               look_neg;
   logic [IDX_W-1:0]   look_idx;
   logic [VW-1:0]      look_var;
   logic [CLIT_W-1:0]  look_pos;
   logic [CLIT_W-1:0]  look_lit;
   logic [1:0]         look_dest;

   // Request decode
   logic [VW-1:0]      name_c;
   req_kind_type       req_kind;
   logic               rsp_free;

   aigcnf_idx_mod #(.GRAPH_VARS(GRAPH_VARS)) u_idx0 (
      .clock     (clock),
      .graph_var (slot0_ff[LIT_W-1:1]),
      .table_idx (idx0)
   );

   aigcnf_idx_mod #(.GRAPH_VARS(GRAPH_VARS)) u_idx1 (
      .clock     (clock),
      .graph_var (slot1_ff[LIT_W-1:1]),
      .table_idx (idx1)
   );

   aigcnf_idx_mod #(.GRAPH_VARS(GRAPH_VARS)) u_idx2 (
      .clock     (clock),
      .graph_var (slot2_ff[LIT_W-1:1]),
      .table_idx (idx2)
   );

   // Clip the name into the CNF variable space
   assign name_c   = (32'(req_ch.var_name) > VAR_MAX32) ? VAR_MAX : VW'(req_ch.var_name);
   assign req_kind = req_kind_type'(req_ch.req_type);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Resolve the word returned for the slot being processed
   always_comb begin
      look_word = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      unique case (step_ff)
         2'd1: begin
            look_neg = slot0_ff[0];
            look_idx = idx0;
         end
         2'd2: begin
            look_neg = slot1_ff[0];
            look_idx = idx1;
         end
         default: begin
            look_neg = slot2_ff[0];
            look_idx = idx2;
         end
      endcase
      look_alloc = !look_word[VW];
      if (!look_alloc) begin
         look_var = look_word[VW-1:0];
      end else if (fresh_ff != VAR_MAX) begin
         look_var = fresh_ff + 1'b1;
      end else begin
         look_var = VAR_MAX;
      end
      look_pos  = CLIT_W'(look_var);
      look_lit  = look_neg ? -look_pos : look_pos;
      look_dest = step_ff + {1'b0, bind_ff} - 2'd1;
   end

   // Next state, memory control and clause selection
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      wait_in      = wait_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      kind_in      = kind_ff;
      form_in      = form_ff;
      nlook_in     = nlook_ff;
      bind_in      = bind_ff;
      name_in      = name_ff;
      slot0_in     = slot0_ff;
      slot1_in     = slot1_ff;
      slot2_in     = slot2_ff;
      lit_l_in     = lit_l_ff;
      lit_r0_in    = lit_r0_ff;
      lit_r1_in    = lit_r1_ff;
      fresh_in     = fresh_ff;
      ovf_in       = ovf_ff;
      ccount_in    = ccount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_lit0_in  = out_lit0_ff;
      out_lit1_in  = out_lit1_ff;
      out_lit2_in  = out_lit2_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      out_vtot_in  = out_vtot_ff;
      out_ctot_in  = out_ctot_ff;
      out_ovf_in   = out_ovf_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_addr_ff;
      mem_wd       = '0;
      mem_ra       = idx0;

      unique case (state_ff)
         // Sweep the table after reset
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         // Take a request and sort out its lookup plan
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in  = req_kind;
               name_in  = name_c;
               slot0_in = req_ch.lit_a;
               slot1_in = req_ch.lit_b;
               slot2_in = req_ch.lit_c;
               bind_in  = 1'b0;
               wait_in  = 1'b0;
               unique case (req_kind)
                  REQ_DECLARE, REQ_RESERVE: begin
                     if (name_c > fresh_ff) begin
                        fresh_in = name_c;
                     end
                     if (req_kind == REQ_DECLARE) begin
                        state_in = ST_INDEX;
                     end
                  end
                  REQ_GATE: begin
                     state_in = ST_INDEX;
                     priority if (req_ch.lit_b == '0 || req_ch.lit_c == '0) begin
                        form_in  = FORM_NEG1;
                        nlook_in = 2'd1;
                     end else if (req_ch.lit_b == LIT_W'(1) && req_ch.lit_c == LIT_W'(1)) begin
                        form_in  = FORM_POS1;
                        nlook_in = 2'd1;
                     end else if (req_ch.lit_b == LIT_W'(1) || req_ch.lit_c == LIT_W'(1)) begin
                        form_in  = FORM_TWO;
                        nlook_in = 2'd2;
                        if (req_ch.lit_b == LIT_W'(1)) begin
                           slot1_in = req_ch.lit_c;
                        end
                     end else begin
                        form_in  = FORM_THREE;
                        nlook_in = 2'd3;
                     end
                  end
                  REQ_BIND: begin
                     state_in = ST_INDEX;
                     bind_in  = 1'b1;
                     lit_l_in = CLIT_W'(name_c);
                     priority if (req_ch.lit_a == '0) begin
                        form_in  = FORM_NEG1;
                        nlook_in = 2'd0;
                     end else if (req_ch.lit_a == LIT_W'(1)) begin
                        form_in  = FORM_POS1;
                        nlook_in = 2'd0;
                     end else begin
                        form_in  = FORM_TWO;
                        nlook_in = 2'd1;
                     end
                  end
               endcase
            end
         end

         // Wait out the index reduction
         ST_INDEX: begin
            wait_in = 1'b1;
            step_in = 2'd0;
            emit_in = 2'd0;
            if (wait_ff) begin
               priority if (kind_ff == REQ_DECLARE) begin
                  state_in = ST_DECLARE;
               end else if (nlook_ff == 2'd0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end

         // Write the declared name
         ST_DECLARE: begin
            mem_we   = 1'b1;
            mem_wa   = idx0;
            mem_wd   = {1'b1, name_ff};
            state_in = ST_IDLE;
         end

         // Issue the next read, resolve the previous one and allocate on a miss
         ST_LOOKUP: begin
            unique case (step_ff)
               2'd0:    mem_ra = idx0;
               2'd1:    mem_ra = idx1;
               default: mem_ra = idx2;
            endcase
            if (step_ff != 2'd0) begin
               if (look_alloc) begin
                  mem_we = 1'b1;
                  mem_wa = look_idx;
                  mem_wd = {1'b1, look_var};
                  if (fresh_ff != VAR_MAX) begin
                     fresh_in = look_var;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               unique case (look_dest)
                  2'd0:    lit_l_in  = look_lit;
                  2'd1:    lit_r0_in = look_lit;
                  default: lit_r1_in = look_lit;
               endcase
            end
            if (step_ff == nlook_ff) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         // Hand out one clause per free response slot
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_lit1_in  = '0;
               out_lit2_in  = '0;
               unique case (form_ff)
                  FORM_NEG1: begin
                     out_lit0_in = -lit_l_ff;
                     out_cnt_in  = 2'd1;
                     out_last_in = 1'b1;
                  end
                  FORM_POS1: begin
                     out_lit0_in = lit_l_ff;
                     out_cnt_in  = 2'd1;
                     out_last_in = 1'b1;
                  end
                  FORM_TWO: begin
                     out_cnt_in  = 2'd2;
                     if (emit_ff == 2'd0) begin
                        out_lit0_in = lit_l_ff;
                        out_lit1_in = -lit_r0_ff;
                        out_last_in = 1'b0;
                     end else begin
                        out_lit0_in = -lit_l_ff;
                        out_lit1_in = lit_r0_ff;
                        out_last_in = 1'b1;
                     end
                  end
                  FORM_THREE: begin
                     unique case (emit_ff)
                        2'd0: begin
                           out_lit0_in = lit_l_ff;
                           out_lit1_in = -lit_r0_ff;
                           out_lit2_in = -lit_r1_ff;
                           out_cnt_in  = 2'd3;
                           out_last_in = 1'b0;
                        end
                        2'd1: begin
                           out_lit0_in = -lit_l_ff;
                           out_lit1_in = lit_r0_ff;
                           out_cnt_in  = 2'd2;
                           out_last_in = 1'b0;
                        end
                        default: begin
                           out_lit0_in = -lit_l_ff;
                           out_lit1_in = lit_r1_ff;
                           out_cnt_in  = 2'd2;
                           out_last_in = 1'b1;
                        end
                     endcase
                  end
               endcase
               if (ccount_ff != {CTOT_W{1'b1}}) begin
                  ccount_in = ccount_ff + 1'b1;
               end
               out_ctot_in = ccount_in;
               out_vtot_in = VTOT_W'(fresh_ff);
               out_ovf_in  = ovf_ff;
               emit_in     = emit_ff + 1'b1;
               if (out_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wait_ff      <= 1'b0;
         step_ff      <= '0;
         emit_ff      <= '0;
         fresh_ff     <= '0;
         ovf_ff       <= 1'b0;
         ccount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wait_ff      <= wait_in;
         step_ff      <= step_in;
         emit_ff      <= emit_in;
         fresh_ff     <= fresh_in;
         ovf_ff       <= ovf_in;
         ccount_ff    <= ccount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and response payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      form_ff     <= form_in;
      nlook_ff    <= nlook_in;
      bind_ff     <= bind_in;
      name_ff     <= name_in;
      slot0_ff    <= slot0_in;
      slot1_ff    <= slot1_in;
      slot2_ff    <= slot2_in;
      lit_l_ff    <= lit_l_in;
      lit_r0_ff   <= lit_r0_in;
      lit_r1_ff   <= lit_r1_in;
      out_lit0_ff <= out_lit0_in;
      out_lit1_ff <= out_lit1_in;
      out_lit2_ff <= out_lit2_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
      out_vtot_ff <= out_vtot_in;
      out_ctot_ff <= out_ctot_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // Renaming memory, read first, with the last write forwarded
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff  <= mem[mem_ra];
      fwd_hit_ff  <= mem_we && (mem_wa == mem_ra);
      fwd_data_ff <= mem_wd;
   end

   // Drive the response channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.clause_lit0  = out_lit0_ff;
   assign rsp_ch.clause_lit1  = out_lit1_ff;
   assign rsp_ch.clause_lit2  = out_lit2_ff;
   assign rsp_ch.lit_count    = out_cnt_ff;
   assign rsp_ch.last_clause  = out_last_ff;
   assign rsp_ch.var_total    = out_vtot_ff;
   assign rsp_ch.clause_total = out_ctot_ff;
   assign rsp_ch.overflow     = out_ovf_ff;

endmodule

`default_nettype wire

>>> tb/aig_to_cnf_tseitin_encoder_core_tb.sv
// Self-checking testbench for the AIG to CNF Tseitin encoder core.
`timescale 1ns / 100ps

module aig_to_cnf_tseitin_encoder_core_tb import aigcnf_pkg::*;;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 9;
   localparam int QUIET_LIMIT    = 250000;  // covers the table clearing pass after reset
   localparam int HOLD_CYCLES    = 400;
   localparam int END_SETTLE     = 30;
   localparam int MAX_DECL_NAME  = 3000;
   localparam int RANDOM_PER_MODE = 60;

   localparam logic [LIT_W-1:0]  LIT_FALSE = '0;
   localparam logic [LIT_W-1:0]  LIT_TRUE  = LIT_W'(1);
   localparam logic [NAME_W-1:0] VAR_LIMIT =
      NAME_W'((64'd1 << CNF_VAR_BITS_DEF) - 64'd1);
   localparam logic [CTOT_W-1:0] CLAUSE_LIMIT = '1;

   typedef enum int {
      MODE_RESET,
      MODE_STEADY,
      MODE_SEND_IDLE,
      MODE_RECV_STALL,
      MODE_BOTH_IDLE,
      MODE_BACKLOG,
      MODE_SATURATE
   } traffic_mode_type;

   typedef struct {
      req_kind_type      kind;
      logic [LIT_W-1:0]  lit_a;
      logic [LIT_W-1:0]  lit_b;
      logic [LIT_W-1:0]  lit_c;
      logic [NAME_W-1:0] name;
   } aig_request_type;

   typedef struct {
      logic signed [CLIT_W-1:0] lit0;
      logic signed [CLIT_W-1:0] lit1;
      logic signed [CLIT_W-1:0] lit2;
      logic [CNT_W-1:0]         count;
      logic                     last;
      logic [VTOT_W-1:0]        vars;
      logic [CTOT_W-1:0]        total;
      logic                     ovf;
   } cnf_clause_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aigcnf_req_if req_ch ();
   aigcnf_rsp_if rsp_ch ();

   aig_to_cnf_tseitin_encoder_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Stimulus and expectation stores
   aig_request_type  pending_requests[$];
   cnf_clause_type   expected_clauses[$];
   logic [LIT_W-2:0] graph_pool[$];

   // Predicted encoder state: renaming table, fresh counter, clause counter
   bit                name_known[GRAPH_VARS_DEF];
   logic [NAME_W-1:0] name_of[GRAPH_VARS_DEF];
   logic [NAME_W-1:0] fresh_var    = '0;
   logic [CTOT_W-1:0] clause_count = '0;
   logic              saw_overflow = 1'b0;

   traffic_mode_type mode        = MODE_RESET;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            requests_queued = 0;
   int            clauses_checked = 0;
   int            error_count     = 0;
   int            kind_seen[4]    = '{default: 0};
   bit            req_fire        = 1'b0;
   int            hold_left       = 0;
   bit            backlog_done    = 1'b0;
   int            quiet_cycles    = 0;
   cnf_clause_type got_want;

   // Clock: 10 ns period
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string field, input longint got, input longint want);
      if (got != want)
         report_error($sformatf("clause %0d %s: got %0d, expected %0d",
                                clauses_checked, field, got, want));
   endtask

   // Map a graph literal to a signed CNF literal, allocating a fresh variable on a miss
   function automatic int map_literal(input logic [LIT_W-1:0] lit);
      logic [LIT_W-2:0] slot;
      int               v;
      slot = lit[LIT_W-1:1];
      if (!name_known[slot]) begin
         if (fresh_var < VAR_LIMIT)
            fresh_var++;
         else
            saw_overflow = 1'b1;
         name_of[slot]    = fresh_var;
         name_known[slot] = 1'b1;
      end
      v = int'(name_of[slot]);
      return lit[0] ? -v : v;
   endfunction

   // Update the predicted state for one request and queue the clauses it yields
   task automatic encode_request(input req_kind_type kind, input logic [LIT_W-1:0] la,
                                 input logic [LIT_W-1:0] lb, input logic [LIT_W-1:0] lc,
                                 input logic [NAME_W-1:0] name);
      int             cl[3][3] = '{default: 0};
      int             width[3] = '{default: 0};
      int             n        = 0;
      int             lhs;
      int             r0;
      int             r1;
      int             v;
      cnf_clause_type c;
      case (kind)
         REQ_DECLARE: begin
            name_of[la[LIT_W-1:1]]    = name;
            name_known[la[LIT_W-1:1]] = 1'b1;
            if (name > fresh_var) fresh_var = name;
         end
         REQ_RESERVE: begin
            if (name > fresh_var) fresh_var = name;
         end
         REQ_GATE: begin
            lhs = map_literal(la);
            if (lb == LIT_FALSE || lc == LIT_FALSE) begin
               cl[0][0] = -lhs; width[0] = 1; n = 1;
            end else if (lb == LIT_TRUE && lc == LIT_TRUE) begin
               cl[0][0] = lhs; width[0] = 1; n = 1;
            end else if (lb == LIT_TRUE || lc == LIT_TRUE) begin
               r0 = map_literal(lb == LIT_TRUE ? lc : lb);
               cl[0][0] = lhs;  cl[0][1] = -r0; width[0] = 2;
               cl[1][0] = -lhs; cl[1][1] = r0;  width[1] = 2;
               n = 2;
            end else begin
               r0 = map_literal(lb);
               r1 = map_literal(lc);
               cl[0][0] = lhs; cl[0][1] = -r0; cl[0][2] = -r1; width[0] = 3;
               cl[1][0] = -lhs; cl[1][1] = r0; width[1] = 2;
               cl[2][0] = -lhs; cl[2][1] = r1; width[2] = 2;
               n = 3;
            end
         end
         default: begin
            v = int'(name);
            if (la == LIT_FALSE) begin
               cl[0][0] = -v; width[0] = 1; n = 1;
            end else if (la == LIT_TRUE) begin
               cl[0][0] = v; width[0] = 1; n = 1;
            end else begin
               r0 = map_literal(la);
               cl[0][0] = v;  cl[0][1] = -r0; width[0] = 2;
               cl[1][0] = -v; cl[1][1] = r0;  width[1] = 2;
               n = 2;
            end
         end
      endcase
      // totals reflect the state after every lookup of the request
      for (int k = 0; k < n; k++) begin
         if (clause_count < CLAUSE_LIMIT) clause_count++;
         c.lit0  = CLIT_W'(cl[k][0]);
         c.lit1  = CLIT_W'(cl[k][1]);
         c.lit2  = CLIT_W'(cl[k][2]);
         c.count = CNT_W'(width[k]);
         c.last  = (k == n - 1);
         c.vars  = fresh_var;
         c.total = clause_count;
         c.ovf   = saw_overflow;
         expected_clauses.push_back(c);
      end
   endtask

   task automatic add_request(input req_kind_type kind, input logic [LIT_W-1:0] la,
                              input logic [LIT_W-1:0] lb, input logic [LIT_W-1:0] lc,
                              input logic [NAME_W-1:0] name);
      aig_request_type r;
      r.kind  = kind;
      r.lit_a = la;
      r.lit_b = lb;
      r.lit_c = lc;
      r.name  = name;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // Gate operand: mostly a known graph variable, sometimes a constant or noise
   function automatic logic [LIT_W-1:0] pick_operand();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return LIT_W'($urandom_range(1));
      if (roll < 70 && graph_pool.size() != 0)
         return {graph_pool[$urandom_range(graph_pool.size() - 1)], 1'($urandom_range(1))};
      return LIT_W'($urandom);
   endfunction

   // Well-formed circuit fragments: declare inputs, build gates on them, bind outputs
   task automatic add_random_requests(input int count);
      int               goal;
      logic [LIT_W-2:0] slot;
      goal = requests_queued + count;
      while (requests_queued < goal) begin
         repeat ($urandom_range(1, 3)) begin
            slot = (LIT_W-1)'($urandom);
            graph_pool.push_back(slot);
            add_request(REQ_DECLARE, {slot, 1'($urandom_range(1))}, LIT_W'($urandom),
                        LIT_W'($urandom), NAME_W'($urandom_range(MAX_DECL_NAME)));
         end
         if ($urandom_range(9) == 0)
            add_request(REQ_RESERVE, LIT_W'($urandom), LIT_W'($urandom), LIT_W'($urandom),
                        NAME_W'($urandom_range(MAX_DECL_NAME)));
         repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(9) < 7 || graph_pool.size() == 0) begin
               slot = (LIT_W-1)'($urandom);
               graph_pool.push_back(slot);
            end else begin
               slot = graph_pool[$urandom_range(graph_pool.size() - 1)];
            end
            add_request(REQ_GATE, {slot, 1'($urandom_range(1))}, pick_operand(),
                        pick_operand(), NAME_W'($urandom));
         end
         repeat ($urandom_range(1, 2))
            add_request(REQ_BIND, pick_operand(), LIT_W'($urandom), LIT_W'($urandom),
                        NAME_W'($urandom));
      end
   endtask

   // Hold until every request is taken and every clause has arrived
   task automatic drain();
      while (pending_requests.size() != 0 || expected_clauses.size() != 0)
         @(posedge clock);
   endtask

   task automatic start_mode(input traffic_mode_type m, input int send_pct,
                             input int recv_pct);
      drain();
      @(posedge clock);
      mode           = m;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Request driver: hold the offered request until taken, then advance the queue
   always @(negedge clock) begin
      if (req_fire)
         void'(pending_requests.pop_front());
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         req_ch.valid <= 1'b1;
      end else if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_ch.valid    <= 1'b1;
         req_ch.req_type <= pending_requests[0].kind;
         req_ch.lit_a    <= pending_requests[0].lit_a;
         req_ch.lit_b    <= pending_requests[0].lit_b;
         req_ch.lit_c    <= pending_requests[0].lit_c;
         req_ch.var_name <= pending_requests[0].name;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Clause receiver: random stalls, plus one long hold-off in backlog mode
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (mode == MODE_BACKLOG && !backlog_done) begin
         backlog_done <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on each accepted request, check each accepted clause
   always @(posedge clock) begin
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         kind_seen[int'(req_ch.req_type)]++;
         encode_request(req_kind_type'(req_ch.req_type), req_ch.lit_a, req_ch.lit_b,
                        req_ch.lit_c, req_ch.var_name);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         clauses_checked++;
         if (expected_clauses.size() == 0) begin
            report_error($sformatf("unexpected clause (%0d %0d %0d), count %0d",
                                   rsp_ch.clause_lit0, rsp_ch.clause_lit1,
                                   rsp_ch.clause_lit2, rsp_ch.lit_count));
         end else begin
            got_want = expected_clauses.pop_front();
            compare_field("clause_lit0", longint'(rsp_ch.clause_lit0), longint'(got_want.lit0));
            compare_field("clause_lit1", longint'(rsp_ch.clause_lit1), longint'(got_want.lit1));
            compare_field("clause_lit2", longint'(rsp_ch.clause_lit2), longint'(got_want.lit2));
            compare_field("lit_count", longint'(rsp_ch.lit_count), longint'(got_want.count));
            compare_field("last_clause", longint'(rsp_ch.last_clause), longint'(got_want.last));
            compare_field("var_total", longint'(rsp_ch.var_total), longint'(got_want.vars));
            compare_field("clause_total", longint'(rsp_ch.clause_total),
                          longint'(got_want.total));
            compare_field("overflow", longint'(rsp_ch.overflow), longint'(got_want.ovf));
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d clauses outstanding",
                  quiet_cycles, expected_clauses.size());
         $display("** aig_to_cnf_tseitin_encoder_core: FAILED **");
         $finish;
      end
   end

   // Test sequence
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_DECLARE;
      req_ch.lit_a    = '0;
      req_ch.lit_b    = '0;
      req_ch.lit_c    = '0;
      req_ch.var_name = '0;
      rsp_ch.ready    = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      start_mode(MODE_STEADY, 0, 0);
      // name zero, symbols with even and odd literals
      add_request(REQ_RESERVE, 17'd0, 17'd0, 17'd0, 20'd0);
      add_request(REQ_DECLARE, 17'd2, 17'd0, 17'd0, 20'd5);
      add_request(REQ_DECLARE, 17'd5, 17'h1FFFF, 17'h1FFFF, 20'd7);
      // constant operands in either position and in pairs
      add_request(REQ_GATE, 17'd6, LIT_FALSE, 17'd4, 20'd0);
      add_request(REQ_GATE, 17'd8, 17'd4, LIT_FALSE, 20'd0);
      add_request(REQ_GATE, 17'd9, LIT_TRUE, LIT_FALSE, 20'd0);
      add_request(REQ_GATE, 17'd10, LIT_TRUE, LIT_TRUE, 20'd0);
      add_request(REQ_GATE, 17'd12, LIT_TRUE, 17'd5, 20'd0);
      add_request(REQ_GATE, 17'd14, 17'd3, LIT_TRUE, 20'd0);
      // full gates, odd lhs, constant lhs looked up as variable zero
      add_request(REQ_GATE, 17'd17, 17'd2, 17'd5, 20'd0);
      add_request(REQ_GATE, 17'd0, 17'd2, 17'd4, 20'd0);
      add_request(REQ_GATE, 17'd1, 17'h1FFFF, 17'h1FFFE, 20'hFFFFF);
      // bindings to constants and to a looked-up variable
      add_request(REQ_BIND, LIT_FALSE, 17'd0, 17'd0, 20'hFFFFF);
      add_request(REQ_BIND, LIT_TRUE, 17'd0, 17'd0, 20'd0);
      add_request(REQ_BIND, 17'd9, 17'd0, 17'd0, 20'h55555);
      add_request(REQ_BIND, 17'h1FFFF, 17'd0, 17'd0, 20'hAAAAA);
      // a symbol named zero shows up as a zero literal inside clauses
      add_request(REQ_DECLARE, 17'h1FFFE, 17'd0, 17'd0, 20'd0);
      add_request(REQ_GATE, 17'd20, 17'h1FFFF, 17'h1FFFE, 20'd0);
      // redeclare an allocated entry, then use it
      add_request(REQ_DECLARE, 17'd6, 17'd0, 17'd0, 20'd50);
      add_request(REQ_GATE, 17'd22, 17'd7, 17'd6, 20'd0);
      add_request(REQ_RESERVE, 17'd0, 17'd0, 17'd0, 20'd100);
      add_request(REQ_BIND, 17'd2, 17'd0, 17'd0, 20'd3);
      add_request(REQ_GATE, 17'd22, 17'd22, 17'd23, 20'd0);
      add_random_requests(RANDOM_PER_MODE);

      start_mode(MODE_SEND_IDLE, 60, 0);
      add_random_requests(RANDOM_PER_MODE);
      start_mode(MODE_RECV_STALL, 0, 60);
      add_random_requests(RANDOM_PER_MODE);
      start_mode(MODE_BOTH_IDLE, 23, 23);
      add_random_requests(RANDOM_PER_MODE);

      // receiver holds off while requests keep coming, so the input backs up
      start_mode(MODE_BACKLOG, 0, 0);
      add_random_requests(25);

      // drive the fresh counter to its maximum, then past it
      start_mode(MODE_SATURATE, 10, 10);
      add_request(REQ_RESERVE, 17'd0, 17'd0, 17'd0, 20'hFFFFE);
      add_random_requests(8);
      add_request(REQ_DECLARE, 17'h1ABCD, 17'd0, 17'd0, 20'hFFFFF);
      add_random_requests(4);

      drain();
      repeat (END_SETTLE) @(posedge clock);
      if (expected_clauses.size() != 0)
         report_error($sformatf("%0d expected clauses never arrived", expected_clauses.size()));

      $display("Run covered %0d requests (%0d declare, %0d reserve, %0d gate, %0d bind)",
               kind_seen[REQ_DECLARE] + kind_seen[REQ_RESERVE] + kind_seen[REQ_GATE] +
               kind_seen[REQ_BIND], kind_seen[REQ_DECLARE], kind_seen[REQ_RESERVE],
               kind_seen[REQ_GATE], kind_seen[REQ_BIND]);
      $display("and %0d clauses under idle, stall and backlog traffic; overflow %0s; %0d errors",
               clauses_checked, saw_overflow ? "reached" : "not reached", error_count);
      if (error_count == 0) begin
         $display("** aig_to_cnf_tseitin_encoder_core: PASSED **");
      end else begin
         $display("** aig_to_cnf_tseitin_encoder_core: FAILED **");
      end
      $finish;
   end

endmodule
